// ===== hdl/lph_pkg.sv =====
// Shared constants and controller/datapath interface types for the LSH projection hash.
`timescale 1ns / 1ps
`default_nettype none
package lph_pkg;

	// Field and register widths
	localparam int PIXEL_W  = 8;
	localparam int WEIGHT_W = 16;
	localparam int OFFSET_W = 16;
	localparam int MUL_W    = 7;
	localparam int WIN_W    = 16;
	localparam int HASH_W   = 32;

	// Datapath widths
	localparam int ACC_W    = 40;
	localparam int FRAC_W   = 12;
	localparam int PW_W     = PIXEL_W + 1 + WEIGHT_W;
	localparam int N2_W     = ACC_W - FRAC_W + 1;
	localparam int DIV_W    = N2_W - 1;
	localparam int REM_W    = WIN_W + 1;
	localparam int CNT_W    = 5;
	localparam int H_W      = DIV_W + 1;
	localparam int PROD_W   = H_W + MUL_W;
	localparam int FOLD_W   = HASH_W + 1;

	// Configuration
	localparam logic [WIN_W-1:0] WIN_RESET = 16'd4;
	localparam int               REG_WINDOW = 0;

	// Hash modulus, 2^32 - 5
	localparam logic [FOLD_W-1:0] HASH_PRIME = 33'd4294967291;
	localparam logic [FOLD_W-1:0] PRIME_FOLD = 33'd5;

	// Controller commands to the datapath
	typedef struct packed {
		logic acc;
		logic capture;
		logic prep;
		logic div_step;
		logic quo;
		logic mul;
		logic fold;
		logic modp;
		logic add;
		logic emit;
	} lph_cmd_t;

	// Datapath status to the controller
	typedef struct packed {
		logic div_last;
		logic last_func;
		logic out_free;
	} lph_sts_t;

endpackage
`default_nettype wire

// ===== hdl/lph_datapath.sv =====
// Datapath: dot-product accumulator, bit-serial floor divider, modular combiner and output register.
`timescale 1ns / 1ps
`default_nettype none
module lph_datapath (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire lph_pkg::lph_cmd_t                    cmd,
	output lph_pkg::lph_sts_t                         sts,
	input  wire logic [lph_pkg::WIN_W-1:0]            window,
	input  wire logic [lph_pkg::PIXEL_W-1:0]          pixel,
	input  wire logic signed [lph_pkg::WEIGHT_W-1:0]  weight,
	input  wire logic [lph_pkg::OFFSET_W-1:0]         offset,
	input  wire logic signed [lph_pkg::MUL_W-1:0]     multiplier,
	input  wire logic                                 last_function,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [lph_pkg::HASH_W-1:0]                hash_value
);

	logic [lph_pkg::ACC_W-1:0]          acc_q;
	logic [lph_pkg::HASH_W-1:0]         sum_q;
	logic [lph_pkg::OFFSET_W-1:0]       off_q;
	logic signed [lph_pkg::MUL_W-1:0]   mul_q;
	logic                               lf_q;
	logic [lph_pkg::WIN_W-1:0]          win_q;
	logic [lph_pkg::REM_W-1:0]          rem_q;
	logic [lph_pkg::DIV_W-1:0]          quo_q;
	logic [lph_pkg::CNT_W-1:0]          cnt_q;
	logic                               neg_q;
	logic signed [lph_pkg::H_W-1:0]     h_q;
	logic signed [lph_pkg::PROD_W-1:0]  prod_q;
	logic [lph_pkg::FOLD_W-1:0]         fold_q;
	logic                               pneg_q;
	logic [lph_pkg::HASH_W-1:0]         res_q;
	logic                               out_valid_q;
	logic [lph_pkg::HASH_W-1:0]         hash_q;

	logic signed [lph_pkg::PW_W-1:0]    pw;
	logic signed [lph_pkg::N2_W-1:0]    n2;
	logic [lph_pkg::N2_W-1:0]           n2_mag;
	logic [lph_pkg::REM_W-1:0]          rem_sh;
	logic [lph_pkg::REM_W-1:0]          rem_diff;
	logic                               rem_ge;
	logic [lph_pkg::H_W-1:0]            q_adj;
	logic [lph_pkg::PROD_W-1:0]         p_mag;
	logic [lph_pkg::FOLD_W-1:0]         fold_sum;
	logic [lph_pkg::HASH_W-1:0]         red;
	logic [lph_pkg::HASH_W-1:0]         res_next;
	logic [lph_pkg::FOLD_W-1:0]         sum_ext;
	logic [lph_pkg::HASH_W-1:0]         sum_next;

	// Pixel times weight, then scale the sum down to whole units and add the offset
	always_comb begin
		pw     = $signed({1'b0, pixel}) * weight;
		n2     = $signed({acc_q[lph_pkg::ACC_W-1], acc_q[lph_pkg::ACC_W-1:lph_pkg::FRAC_W]})
			+ $signed({{(lph_pkg::N2_W - lph_pkg::OFFSET_W){1'b0}}, off_q});
		n2_mag = n2[lph_pkg::N2_W-1] ? (~n2 + lph_pkg::N2_W'(1)) : n2;
	end

	// One restoring division step on the magnitude
	always_comb begin
		rem_sh   = {rem_q[lph_pkg::REM_W-2:0], quo_q[lph_pkg::DIV_W-1]};
		rem_diff = rem_sh - {1'b0, win_q};
		rem_ge   = (rem_sh >= {1'b0, win_q});
	end

	// Floor toward minus infinity for a negative dividend
	always_comb begin
		q_adj = {1'b0, quo_q} + lph_pkg::H_W'(neg_q && (rem_q != '0));
	end

	// Fold the product magnitude below 2^32 + 20 using 2^32 = 5 mod prime
	always_comb begin
		p_mag    = prod_q[lph_pkg::PROD_W-1] ? (~prod_q + lph_pkg::PROD_W'(1)) : prod_q;
		fold_sum = {1'b0, p_mag[lph_pkg::HASH_W-1:0]}
			+ lph_pkg::FOLD_W'(p_mag[lph_pkg::PROD_W-2:lph_pkg::HASH_W]) * lph_pkg::PRIME_FOLD;
	end

	// Final reduction and sign fixup, then the running sum update
	always_comb begin
		red      = (fold_q >= lph_pkg::HASH_PRIME) ?
			lph_pkg::HASH_W'(fold_q - lph_pkg::HASH_PRIME) : fold_q[lph_pkg::HASH_W-1:0];
		res_next = (pneg_q && (red != '0)) ?
			(lph_pkg::HASH_PRIME[lph_pkg::HASH_W-1:0] - red) : red;
		sum_ext  = {1'b0, sum_q} + {1'b0, res_q};
		sum_next = (sum_ext >= lph_pkg::HASH_PRIME) ?
			lph_pkg::HASH_W'(sum_ext - lph_pkg::HASH_PRIME) : sum_ext[lph_pkg::HASH_W-1:0];
	end

	// Accumulators and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.acc) begin
				acc_q <= acc_q + {{(lph_pkg::ACC_W - lph_pkg::PW_W){pw[lph_pkg::PW_W-1]}}, pw};
			end else if (cmd.prep) begin
				acc_q <= '0;
			end
			if (cmd.add) begin
				sum_q <= sum_next;
			end else if (cmd.emit) begin
				sum_q <= '0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Per-function operands, divider and combiner pipeline registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			off_q <= offset;
			mul_q <= multiplier;
			lf_q  <= last_function;
		end
		if (cmd.prep) begin
			win_q <= (window == '0) ? lph_pkg::WIN_W'(1) : window;
			rem_q <= '0;
			quo_q <= n2_mag[lph_pkg::DIV_W-1:0];
			neg_q <= n2[lph_pkg::N2_W-1];
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_diff : rem_sh;
			quo_q <= {quo_q[lph_pkg::DIV_W-2:0], rem_ge};
			cnt_q <= cnt_q + lph_pkg::CNT_W'(1);
		end
		if (cmd.quo) begin
			h_q <= neg_q ? $signed(~q_adj + lph_pkg::H_W'(1)) : $signed(q_adj);
		end
		if (cmd.mul) begin
			prod_q <= lph_pkg::PROD_W'(mul_q) * lph_pkg::PROD_W'(h_q);
		end
		if (cmd.fold) begin
			fold_q <= fold_sum;
			pneg_q <= prod_q[lph_pkg::PROD_W-1];
		end
		if (cmd.modp) begin
			res_q <= res_next;
		end
		if (cmd.emit) begin
			hash_q <= sum_q;
		end
	end

	// Status back to the controller
	always_comb begin
		sts.div_last  = (cnt_q == lph_pkg::CNT_W'(lph_pkg::DIV_W - 1));
		sts.last_func = lf_q;
		sts.out_free  = !out_valid_q || !out_stall;
	end

	assign out_valid  = out_valid_q;
	assign hash_value = hash_q;

endmodule
`default_nettype wire

// ===== hdl/lph_ctrl.sv =====
// Controller: sequences accumulation, division, modular combine and result emission.
`timescale 1ns / 1ps
`default_nettype none
module lph_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               last_pixel,
	output logic                    in_stall,
	input  wire lph_pkg::lph_sts_t  sts,
	output lph_pkg::lph_cmd_t       cmd
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_PREP = 8'b0000_0010,
		ST_DIV  = 8'b0000_0100,
		ST_QUO  = 8'b0000_1000,
		ST_MUL  = 8'b0001_0000,
		ST_FOLD = 8'b0010_0000,
		ST_MOD  = 8'b0100_0000,
		ST_ADD  = 8'b1000_0000
	} lph_state_t;

	lph_state_t state_q;
	lph_state_t state_next;
	logic       emit_wait_q;
	logic       emit_wait_next;

	// Next state and commands
	always_comb begin
		state_next     = state_q;
		emit_wait_next = emit_wait_q;
		cmd            = '0;
		in_stall       = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (emit_wait_q) begin
					// hold input until the result beat gets into the output register
					if (sts.out_free) begin
						cmd.emit       = 1'b1;
						emit_wait_next = 1'b0;
					end
				end else begin
					in_stall = 1'b0;
					cmd.acc  = in_valid;
					if (in_valid && last_pixel) begin
						cmd.capture = 1'b1;
						state_next  = ST_PREP;
					end
				end
			end
			ST_PREP: begin
				cmd.prep   = 1'b1;
				state_next = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_next = ST_QUO;
				end
			end
			ST_QUO: begin
				cmd.quo    = 1'b1;
				state_next = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul    = 1'b1;
				state_next = ST_FOLD;
			end
			ST_FOLD: begin
				cmd.fold   = 1'b1;
				state_next = ST_MOD;
			end
			ST_MOD: begin
				cmd.modp   = 1'b1;
				state_next = ST_ADD;
			end
			ST_ADD: begin
				cmd.add        = 1'b1;
				emit_wait_next = sts.last_func;
				state_next     = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			emit_wait_q <= 1'b0;
		end else begin
			state_q     <= state_next;
			emit_wait_q <= emit_wait_next;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/lsh_projection_hash.sv =====
// Top level: APB window register, controller and datapath of the LSH projection hash.
// Throughput: one pixel beat per cycle while a hash function is accumulating.
// After the last pixel of a function the input stalls through one setup step, the 28-bit
// one-bit-per-cycle floor divider, then sign, multiply, fold, reduce and sum steps.
// On the last function a further step moves the sum to the output register, which drives
// hash_value; that step waits while a previous result is held by out_stall.
// Reset (arst_n low, asynchronous) clears both accumulators and out_valid, and sets window to 4.
`timescale 1ns / 1ps
`default_nettype none
module lsh_projection_hash (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [2:0]                           paddr,
	input  wire logic [31:0]                          pwdata,
	output logic [31:0]                               prdata,
	output logic                                      pready,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [lph_pkg::PIXEL_W-1:0]          pixel,
	input  wire logic signed [lph_pkg::WEIGHT_W-1:0]  weight,
	input  wire logic                                 last_pixel,
	input  wire logic [lph_pkg::OFFSET_W-1:0]         offset,
	input  wire logic signed [lph_pkg::MUL_W-1:0]     multiplier,
	input  wire logic                                 last_function,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [lph_pkg::HASH_W-1:0]                hash_value
);

	logic [lph_pkg::WIN_W-1:0] window_q;
	logic                      win_sel;
	lph_pkg::lph_cmd_t         cmd;
	lph_pkg::lph_sts_t         sts;

	// Register decode: paddr[2] alone selects the window register
	assign win_sel = (paddr[2] == 1'(lph_pkg::REG_WINDOW));
	assign pready  = 1'b1;
	assign prdata  = win_sel ? 32'(window_q) : '0;

	// Window register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= lph_pkg::WIN_RESET;
		end else if (psel && penable && pwrite && pready && win_sel) begin
			window_q <= pwdata[lph_pkg::WIN_W-1:0];
		end
	end

	lph_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.last_pixel (last_pixel),
		.in_stall   (in_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	lph_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.window        (window_q),
		.pixel         (pixel),
		.weight        (weight),
		.offset        (offset),
		.multiplier    (multiplier),
		.last_function (last_function),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.hash_value    (hash_value)
	);

endmodule
`default_nettype wire
